[hw/rtl/humidity_frame_decoder_defines.svh]
// ---------------------------------------------------------------------------
// Humidity frame decoder assertion macros
// Shared property wrappers for the checker. Each one is clocked on clk and
// switched off during reset.
// ---------------------------------------------------------------------------
`ifndef HUMIDITY_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication.
`define HFD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("humidity frame decoder check failed");

// Next-cycle implication.
`define HFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("humidity frame decoder check failed");

`endif

[hw/rtl/hfd_pkg.sv]
// ---------------------------------------------------------------------------
// Humidity frame decoder package
// Frame positions, status codes, conversion constants and the CRC-8 step.
// ---------------------------------------------------------------------------
package hfd_pkg;

    localparam int FRAME_BYTES = 6;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t POS_T_MSB = pos_t'(0);
    localparam pos_t POS_T_LSB = pos_t'(1);
    localparam pos_t POS_T_CRC = pos_t'(2);
    localparam pos_t POS_H_MSB = pos_t'(3);
    localparam pos_t POS_H_LSB = pos_t'(4);
    localparam pos_t POS_H_CRC = pos_t'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUS_ERR  = 2'd1,
        ST_TEMP_CRC = 2'd2,
        ST_HUM_CRC  = 2'd3
    } status_t;

    localparam logic [7:0]         CRC_INIT    = 8'hFF;
    localparam logic [7:0]         CRC_POLY    = 8'h31;
    localparam logic [14:0]        TEMP_SCALE  = 15'd17500;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
    localparam logic [13:0]        HUM_SCALE   = 14'd10000;

    // Controls passed from the sequencer to the conversion registers.
    typedef struct packed {
        logic       load_temp;
        logic       load_humid;
        logic [7:0] msb;
    } ctrl_t;

    // One byte through the MSB-first CRC-8 shift register.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/hfd_seq.sv]
// ---------------------------------------------------------------------------
// Humidity frame decoder sequencer
// Tracks the byte position, runs the word CRC a byte at a time and decides
// when a result is due and with which status.
// ---------------------------------------------------------------------------
module hfd_seq
    import hfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic       frame_start,
    input  logic       bus_fault,
    output ctrl_t      ctrl,
    output logic       fire,
    output status_t    res_status
);

    pos_t       byte_pos_reg, byte_pos_next;
    logic [7:0] word_high_reg, word_high_next;
    logic [7:0] crc_reg, crc_next;
    logic       temp_good_reg, temp_good_next;
    pos_t       pos_eff;
    logic       load_temp;
    logic       load_humid;

    assign pos_eff = frame_start ? POS_T_MSB : byte_pos_reg;

    always_comb
    begin
        byte_pos_next  = byte_pos_reg;
        word_high_next = word_high_reg;
        crc_next       = crc_reg;
        temp_good_next = temp_good_reg;
        load_temp      = 1'b0;
        load_humid     = 1'b0;
        fire           = 1'b0;
        res_status     = ST_OK;
        if (bus_fault)
        begin
            byte_pos_next = POS_T_MSB;
            fire          = 1'b1;
            res_status    = ST_BUS_ERR;
        end
        else
        begin
            unique case (pos_eff)
                POS_T_LSB:
                begin
                    crc_next      = crc8_feed(crc_reg, rx_byte);
                    load_temp     = 1'b1;
                    byte_pos_next = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    temp_good_next = (crc_reg == rx_byte);
                    byte_pos_next  = POS_H_MSB;
                end
                POS_H_MSB:
                begin
                    word_high_next = rx_byte;
                    crc_next       = crc8_feed(CRC_INIT, rx_byte);
                    byte_pos_next  = POS_H_LSB;
                end
                POS_H_LSB:
                begin
                    crc_next      = crc8_feed(crc_reg, rx_byte);
                    load_humid    = 1'b1;
                    byte_pos_next = POS_H_CRC;
                end
                POS_H_CRC:
                begin
                    byte_pos_next = POS_T_MSB;
                    fire          = 1'b1;
                    if (!temp_good_reg)
                    begin
                        res_status = ST_TEMP_CRC;
                    end
                    else if (crc_reg != rx_byte)
                    begin
                        res_status = ST_HUM_CRC;
                    end
                    else
                    begin
                        res_status = ST_OK;
                    end
                end
                default:
                begin
                    // First byte of a frame; unused position codes land here too.
                    word_high_next = rx_byte;
                    crc_next       = crc8_feed(CRC_INIT, rx_byte);
                    byte_pos_next  = POS_T_LSB;
                end
            endcase
        end
    end

    assign ctrl.load_temp  = step & load_temp;
    assign ctrl.load_humid = step & load_humid;
    assign ctrl.msb        = word_high_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg  <= POS_T_MSB;
            word_high_reg <= '0;
            crc_reg       <= '0;
            temp_good_reg <= 1'b0;
        end
        else if (step)
        begin
            byte_pos_reg  <= byte_pos_next;
            word_high_reg <= word_high_next;
            crc_reg       <= crc_next;
            temp_good_reg <= temp_good_next;
        end
    end

endmodule

[hw/rtl/hfd_conv.sv]
// ---------------------------------------------------------------------------
// Humidity frame decoder conversion
// Scales each raw word to hundredths as soon as its low byte arrives and
// holds the value until the frame ends.
// ---------------------------------------------------------------------------
module hfd_conv
    import hfd_pkg::*;
(
    input  logic               clk,
    input  ctrl_t              ctrl,
    input  logic [7:0]         rx_byte,
    output logic signed [14:0] temp_centi,
    output logic [13:0]        humid_centi
);

    logic [15:0]        raw;
    logic [30:0]        temp_prod;
    logic [29:0]        hum_prod;
    logic signed [15:0] temp_wide;
    logic signed [14:0] temp_reg, temp_next;
    logic [13:0]        humid_reg, humid_next;

    assign raw       = {ctrl.msb, rx_byte};
    assign temp_prod = {15'd0, raw} * {16'd0, TEMP_SCALE};
    assign hum_prod  = {14'd0, raw} * {16'd0, HUM_SCALE};

    // The scaled temperature reaches 17499, so the offset is taken in 16 bits.
    assign temp_wide  = $signed({1'b0, temp_prod[30:16]}) - TEMP_OFFSET;
    assign temp_next  = temp_wide[14:0];
    assign humid_next = hum_prod[29:16];

    always_ff @(posedge clk)
    begin
        if (ctrl.load_temp)
        begin
            temp_reg <= temp_next;
        end
        if (ctrl.load_humid)
        begin
            humid_reg <= humid_next;
        end
    end

    assign temp_centi  = temp_reg;
    assign humid_centi = humid_reg;

endmodule

[hw/rtl/humidity_frame_decoder.sv]
// ---------------------------------------------------------------------------
// Humidity frame decoder
// Decodes six-byte temperature/humidity responses with CRC-8 word checks.
// ---------------------------------------------------------------------------
// Bytes enter on the input channel (in_valid, in_stall, rx_byte, frame_start,
// bus_fault): temperature msb, lsb, CRC, then humidity msb, lsb, CRC. A byte
// with frame_start restarts the frame; a byte with bus_fault aborts it and
// yields a bus-error word at once.
// One result word per frame (or per fault) leaves on the output channel
// (out_valid, out_stall, status, temp_centi, humid_centi). Values are zero
// whenever status is not ok.
// A byte is loaded into the input register when it is accepted, and its
// result is loaded into the result register when that byte advances out of
// it. Throughput is one byte per cycle while the receiver does not stall,
// set by the single decode pass between those two registers.
// Reset clears the byte position, so the next byte counts as a frame start,
// and empties both registers. While the receiver stalls, the result word
// holds; one more byte can wait in the input register, after which in_stall
// rises until the result is taken.
// ---------------------------------------------------------------------------
module humidity_frame_decoder
    import hfd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    input  logic               frame_start,
    input  logic               bus_fault,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [14:0] temp_centi,
    output logic [13:0]        humid_centi
);

    logic               s1_valid_reg, s1_valid_next;
    logic [7:0]         s1_byte_reg;
    logic               s1_start_reg;
    logic               s1_fault_reg;
    logic               advance;
    logic               fire;
    status_t            res_status;
    ctrl_t              ctrl;
    logic signed [14:0] conv_temp;
    logic [13:0]        conv_humid;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg;
    logic signed [14:0] out_temp_reg;
    logic [13:0]        out_humid_reg;

    assign advance       = s1_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall      = s1_valid_reg & ~advance;
    assign s1_valid_next = (in_valid & ~in_stall) | (s1_valid_reg & ~advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid & ~in_stall)
        begin
            s1_byte_reg  <= rx_byte;
            s1_start_reg <= frame_start;
            s1_fault_reg <= bus_fault;
        end
    end

    hfd_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .rx_byte     (s1_byte_reg),
        .frame_start (s1_start_reg),
        .bus_fault   (s1_fault_reg),
        .ctrl        (ctrl),
        .fire        (fire),
        .res_status  (res_status)
    );

    hfd_conv u_conv (
        .clk         (clk),
        .ctrl        (ctrl),
        .rx_byte     (s1_byte_reg),
        .temp_centi  (conv_temp),
        .humid_centi (conv_humid)
    );

    assign out_valid_next = (advance & fire) | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance & fire)
        begin
            out_status_reg <= res_status;
            out_temp_reg   <= (res_status == ST_OK) ? conv_temp : 15'sd0;
            out_humid_reg  <= (res_status == ST_OK) ? conv_humid : 14'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign temp_centi  = out_temp_reg;
    assign humid_centi = out_humid_reg;

endmodule

[hw/rtl/hfd_checker.sv]
// ---------------------------------------------------------------------------
// Humidity frame decoder checker
// Port-level properties of the decoder, bound to the top level.
// ---------------------------------------------------------------------------
`include "humidity_frame_decoder_defines.svh"

module hfd_checker
    import hfd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic signed [14:0] temp_centi,
    input logic [13:0]        humid_centi
);

    logic        err_word;
    logic        ok_word;
    logic        vals_zero;
    logic        in_range;
    logic [30:0] out_word;

    assign err_word  = out_valid && (status != ST_OK);
    assign ok_word   = out_valid && (status == ST_OK);
    assign vals_zero = (temp_centi == 15'sd0) && (humid_centi == 14'd0);
    assign in_range  = (temp_centi >= -15'sd4500) && (temp_centi <= 15'sd12999)
                       && (humid_centi <= 14'd9999);
    assign out_word  = {status, temp_centi, humid_centi};

    // An error word never carries measurement values.
    `HFD_ASSERT_IMPLY(a_err_zero, err_word, vals_zero)

    // A good word stays inside the sensor range.
    `HFD_ASSERT_IMPLY(a_ok_range, ok_word, in_range)

    // With no result pending the input side is never held off.
    `HFD_ASSERT_IMPLY(a_no_stall_idle, !out_valid, !in_stall)

    // A stalled result word holds.
    `HFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind humidity_frame_decoder hfd_checker u_hfd_checker (.*);

[sim/tb_humidity_frame_decoder.sv]
// ---------------------------------------------------------------------------
// Humidity frame decoder testbench
// Sends six-byte temperature/humidity responses with good and corrupted
// CRC bytes, restarts, partial frames and bus faults. Both channels idle
// and stall at random. A scoreboard decodes every accepted byte on its own
// and checks each result word field by field, in order.
// ---------------------------------------------------------------------------
module tb_humidity_frame_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    import hfd_pkg::*;

    typedef struct {
        status_t            st;
        logic signed [14:0] temp;
        logic [13:0]        hum;
    } reading_t;

    class frame_scoreboard;
        localparam int unsigned TEMP_GAIN = 17500;
        localparam int unsigned HUM_GAIN  = 10000;
        localparam int          TEMP_BASE = 4500;

        pos_t        pos;
        logic [7:0]  msb_hold;
        logic [15:0] t_raw;
        bit          t_crc_ok;
        logic [15:0] h_raw;
        reading_t    readings_due[$];
        int          faults;

        function new();
            pos      = POS_T_MSB;
            msb_hold = '0;
            t_raw    = '0;
            t_crc_ok = 1'b0;
            h_raw    = '0;
            faults   = 0;
        endfunction

        // CRC-8 over a 16-bit word, fed one data bit at a time, msb first.
        static function logic [7:0] word_crc(input logic [15:0] w);
            logic [7:0] c;
            logic       fb;
            c = 8'hFF;
            for (int i = 15; i >= 0; i--)
            begin
                fb = c[7] ^ w[i];
                c  = {c[6:0], 1'b0};
                if (fb)
                begin
                    c = c ^ 8'h31;
                end
            end
            return c;
        endfunction

        function void take_byte(input logic [7:0] b, input logic start, input logic fault);
            reading_t    r;
            int unsigned tq;
            int unsigned hq;
            int          tc;
            if (fault)
            begin
                pos    = POS_T_MSB;
                r.st   = ST_BUS_ERR;
                r.temp = '0;
                r.hum  = '0;
                readings_due.push_back(r);
                return;
            end
            if (start)
            begin
                pos = POS_T_MSB;
            end
            case (pos)
                POS_T_LSB:
                begin
                    t_raw = {msb_hold, b};
                    pos   = POS_T_CRC;
                end
                POS_T_CRC:
                begin
                    t_crc_ok = (word_crc(t_raw) == b);
                    pos      = POS_H_MSB;
                end
                POS_H_MSB:
                begin
                    msb_hold = b;
                    pos      = POS_H_LSB;
                end
                POS_H_LSB:
                begin
                    h_raw = {msb_hold, b};
                    pos   = POS_H_CRC;
                end
                POS_H_CRC:
                begin
                    pos    = POS_T_MSB;
                    r.temp = '0;
                    r.hum  = '0;
                    if (!t_crc_ok)
                    begin
                        r.st = ST_TEMP_CRC;
                    end
                    else if (word_crc(h_raw) != b)
                    begin
                        r.st = ST_HUM_CRC;
                    end
                    else
                    begin
                        tq     = (32'(t_raw) * TEMP_GAIN) >> 16;
                        hq     = (32'(h_raw) * HUM_GAIN) >> 16;
                        tc     = int'(tq) - TEMP_BASE;
                        r.st   = ST_OK;
                        r.temp = tc[14:0];
                        r.hum  = hq[13:0];
                    end
                    readings_due.push_back(r);
                end
                default:
                begin
                    msb_hold = b;
                    pos      = POS_T_LSB;
                end
            endcase
        endfunction

        function void check_result(input logic [1:0] st, input logic signed [14:0] temp,
                                   input logic [13:0] hum);
            reading_t exp;
            if (readings_due.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                begin
                    $display("unexpected result word: status %0d temp %0d hum %0d",
                             st, temp, hum);
                end
                return;
            end
            exp = readings_due.pop_front();
            if (st !== exp.st || temp !== exp.temp || hum !== exp.hum)
            begin
                faults++;
                if (faults <= 10)
                begin
                    $display("result mismatch: expected status %0d temp %0d hum %0d, got status %0d temp %0d hum %0d",
                             exp.st, exp.temp, exp.hum, st, temp, hum);
                end
            end
        endfunction
    endclass

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [7:0]         rx_byte     = 8'h00;
    logic               frame_start = 1'b0;
    logic               bus_fault   = 1'b0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [1:0]         status;
    logic signed [14:0] temp_centi;
    logic [13:0]        humid_centi;

    frame_scoreboard sb = new();
    bit              calm = 1'b0;
    int              items_sent = 0;
    int              hold_left = 0;

    humidity_frame_decoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .bus_fault   (bus_fault),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .temp_centi  (temp_centi),
        .humid_centi (humid_centi)
    );

    always #4 clk = ~clk;

    // During calm stretches neither side idles.
    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 15));
    endfunction

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic start, input logic fault);
        int gap;
        rx_byte     <= b;
        frame_start <= start;
        bus_fault   <= fault;
        in_valid    <= 1'b1;
        do @(posedge clk); while (in_stall !== 1'b0);
        sb.take_byte(b, start, fault);
        items_sent++;
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_frame(input logic [15:0] t_word, input bit t_ok,
                              input logic [15:0] h_word, input bit h_ok,
                              input logic first_start);
        logic [7:0] tc;
        logic [7:0] hc;
        tc = frame_scoreboard::word_crc(t_word);
        hc = frame_scoreboard::word_crc(h_word);
        if (!t_ok)
        begin
            tc = tc ^ 8'($urandom_range(1, 255));
        end
        if (!h_ok)
        begin
            hc = hc ^ 8'($urandom_range(1, 255));
        end
        send_byte(t_word[15:8], first_start, 1'b0);
        send_byte(t_word[7:0], 1'b0, 1'b0);
        send_byte(tc, 1'b0, 1'b0);
        send_byte(h_word[15:8], 1'b0, 1'b0);
        send_byte(h_word[7:0], 1'b0, 1'b0);
        send_byte(hc, 1'b0, 1'b0);
    endtask

    // A frame cut short, optionally ended by a bus fault.
    task automatic send_partial(input int n, input bit end_fault);
        for (int i = 0; i < n; i++)
        begin
            send_byte(8'($urandom), (i == 0), 1'b0);
        end
        if (end_fault)
        begin
            send_byte(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // Result side: each result word is held off for a random number of cycles.
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1)
        begin
            if (!out_stall)
            begin
                sb.check_result(status, temp_centi, humid_centi);
                hold_left = draw_gap();
                out_stall <= (hold_left > 0);
            end
            else
            begin
                hold_left--;
                out_stall <= (hold_left > 0);
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bus fault between frames, with frame_start also set.
        send_byte(8'hFF, 1'b1, 1'b1);
        // Extreme raw words with good checks, then a frame that follows by wrap with a bad humidity check.
        send_frame(16'h0000, 1'b1, 16'hFFFF, 1'b1, 1'b1);
        send_frame(16'hFFFF, 1'b1, 16'h0000, 1'b0, 1'b0);
        // Restart in mid-frame into a frame with both checks bad.
        send_partial(2, 1'b0);
        send_frame(16'($urandom), 1'b0, 16'($urandom), 1'b0, 1'b1);
        // Bus fault in mid-frame.
        send_partial(3, 1'b1);

        while (items_sent < 1675)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                calm = !calm;
            end
            case ($urandom_range(0, 19))
                15, 16:  send_partial($urandom_range(1, 5), 1'b0);
                17:      send_partial($urandom_range(1, 5), 1'b1);
                18:      send_byte(8'($urandom), 1'($urandom), 1'($urandom));
                19:      send_byte(8'($urandom), 1'($urandom), 1'b1);
                default: send_frame(pick_raw(), ($urandom_range(0, 5) != 0),
                                    pick_raw(), ($urandom_range(0, 5) != 0),
                                    1'($urandom));
            endcase
        end
        in_valid <= 1'b0;

        while (sb.readings_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (16) @(posedge clk);
        if (sb.faults == 0 && sb.readings_due.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
